/* sv/lfd_pkg.sv */
`timescale 1ns / 1ps

package lfd_pkg;

  // Frame layout constants.
  localparam logic [7:0]         HdrByte     = 8'h59;
  localparam int unsigned        PayloadLen  = 6;
  localparam int unsigned        IdxW        = $clog2(PayloadLen + 1);
  localparam logic [15:0]        MarkerReset = 16'd66;
  localparam logic signed [16:0] TempOffset  = 17'sd2048;

  // One complete frame as handed from the front end to the back end.
  typedef struct packed {
    logic [PayloadLen-1:0][7:0] payload;
    logic                       sum_ok;
  } frame_t;

endpackage

/* sv/lfd_front.sv */
`timescale 1ns / 1ps

module lfd_front import lfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output frame_t     push_frame_o
);

  typedef enum logic [1:0] {
    PhHunt1,
    PhHunt2,
    PhCollect
  } phase_e;

  phase_e                 phase_q;
  logic [IdxW-1:0]        idx_q;
  logic [7:0]             sum_q;
  logic [PayloadLen-1:0][7:0] payload_q;

  logic last_byte;

  // The word after the sixth payload byte is the checksum.
  assign last_byte = (phase_q == PhCollect) && (idx_q == IdxW'(PayloadLen));

  assign push_o              = take_i && last_byte;
  assign push_frame_o.payload = payload_q;
  assign push_frame_o.sum_ok  = (rx_byte_i == sum_q);

  // Payload capture; every entry is written in a frame before it is read.
  always_ff @(posedge clk_i) begin
    if (take_i && (phase_q == PhCollect) && !last_byte) begin
      payload_q[idx_q[$clog2(PayloadLen)-1:0]] <= rx_byte_i;
    end
  end

  // Header hunt, byte count and running sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt1;
      idx_q   <= '0;
      sum_q   <= '0;
    end else if (take_i) begin
      unique case (phase_q)
        PhCollect: begin
          if (last_byte) begin
            phase_q <= PhHunt1;
            idx_q   <= '0;
          end else begin
            sum_q <= sum_q + rx_byte_i;
            idx_q <= idx_q + 1'b1;
          end
        end
        PhHunt2: begin
          if (rx_byte_i == HdrByte) begin
            sum_q   <= sum_q + HdrByte;
            idx_q   <= '0;
            phase_q <= PhCollect;
          end else begin
            phase_q <= PhHunt1;
          end
        end
        default: begin
          if (rx_byte_i == HdrByte) begin
            sum_q   <= HdrByte;
            phase_q <= PhHunt2;
          end else begin
            phase_q <= PhHunt1;
          end
          idx_q <= '0;
        end
      endcase
    end
  end

endmodule

/* sv/lfd_queue.sv */
`timescale 1ns / 1ps

module lfd_queue import lfd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t push_frame_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   nonempty_o,
  output frame_t head_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  frame_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [PtrW:0]     count_q;

  assign full_o     = (count_q == (PtrW+1)'(Depth));
  assign nonempty_o = (count_q != '0);
  assign head_o     = mem_q[rd_ptr_q];

  // Storage is written only on a push.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_frame_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* sv/lfd_back.sv */
`timescale 1ns / 1ps

module lfd_back import lfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               nonempty_i,
  input  frame_t             head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        range_cm_o,
  output logic [15:0]        strength_o,
  output logic signed [16:0] temperature_eighths_o,
  output logic               checksum_ok_o
);

  logic [15:0]        marker_q;
  logic               valid_q;
  logic [15:0]        dist_q;
  logic [15:0]        str_q;
  logic signed [16:0] temp_q;
  logic               ok_q;

  logic               slot_free;
  logic signed [16:0] temp_raw;

  // The output register is free when empty or being taken this cycle.
  assign slot_free = !valid_q || !out_stall_i;
  assign pop_o     = nonempty_i && slot_free;
  assign temp_raw  = $signed({1'b0, head_i.payload[5], head_i.payload[4]}) - TempOffset;

  // Bad-frame marker register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= MarkerReset;
    end else if (cfg_we_i) begin
      marker_q <= cfg_wdata_i;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (slot_free) begin
      valid_q <= nonempty_i;
    end
  end

  // Result formatting into the output register.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ok_q <= head_i.sum_ok;
      if (head_i.sum_ok) begin
        dist_q <= {head_i.payload[1], head_i.payload[0]};
        str_q  <= {head_i.payload[3], head_i.payload[2]};
        temp_q <= temp_raw;
      end else begin
        dist_q <= marker_q;
        str_q  <= marker_q;
        temp_q <= '0;
      end
    end
  end

  assign out_valid_o           = valid_q;
  assign range_cm_o            = dist_q;
  assign strength_o            = str_q;
  assign temperature_eighths_o = temp_q;
  assign checksum_ok_o         = ok_q;

endmodule

/* sv/lidar_frame_deframer.sv */
`timescale 1ns / 1ps
// Deframer for the 9-byte lidar range frame: two 0x59 header bytes, six
// payload bytes and a modulo-256 checksum over the first eight bytes.
// Input channel: one received byte per word on rx_byte_i, taken at an edge
// with in_valid_i high and in_stall_o low. Output channel: one result word
// per frame (range, strength, temperature in eighths of a degree and a
// checksum flag), taken at an edge with out_valid_o high and out_stall_i low.
// A failed checksum reports the bad-frame marker as range and strength.
// Throughput is one byte per cycle while in_stall_o is low; the front end
// updates the header hunt and running sum for each byte it takes. The edge
// that takes the checksum byte writes the frame into the frame queue; from
// there it is loaded into the output register once that register is free.
// A two-entry frame queue sits between the byte front end and the output
// register, so the input keeps flowing while a result waits; in_stall_o is
// high while the queue is full, which happens only after the output stalls.
// Reset clears the header hunt, the queue and the output valid flag, and
// sets the marker to 66. The marker is written through cfg_we_i; the user
// must do so only while the block is idle, which the block does not enforce.
module lidar_frame_deframer import lfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        range_cm_o,
  output logic [15:0]        strength_o,
  output logic signed [16:0] temperature_eighths_o,
  output logic               checksum_ok_o
);

  logic   take;
  logic   push;
  frame_t push_frame;
  logic   pop;
  logic   full;
  logic   nonempty;
  frame_t head;

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  lfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .rx_byte_i    (rx_byte_i),
    .push_o       (push),
    .push_frame_o (push_frame)
  );

  lfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_frame_i (push_frame),
    .pop_i        (pop),
    .full_o       (full),
    .nonempty_o   (nonempty),
    .head_o       (head)
  );

  lfd_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .nonempty_i            (nonempty),
    .head_i                (head),
    .pop_o                 (pop),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .range_cm_o            (range_cm_o),
    .strength_o            (strength_o),
    .temperature_eighths_o (temperature_eighths_o),
    .checksum_ok_o         (checksum_ok_o)
  );

endmodule

/* sv/lfd_checker.sv */
`timescale 1ns / 1ps

module lfd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [15:0]        range_cm_o,
  input logic [15:0]        strength_o,
  input logic signed [16:0] temperature_eighths_o,
  input logic               checksum_ok_o
);

  // A stalled result stays and holds its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(range_cm_o)
      && $stable(strength_o) && $stable(temperature_eighths_o)
      && $stable(checksum_ok_o))
    else $error("stalled result changed");

  // A bad frame shows the marker twice and a zero temperature.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !checksum_ok_o |->
      (range_cm_o == strength_o) && (temperature_eighths_o == '0))
    else $error("bad frame fields inconsistent");

  // A good temperature never lies below minus 2048 eighths.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && temperature_eighths_o[16] |-> temperature_eighths_o[15:11] == 5'b11111)
    else $error("temperature below offset");

  // The input stalls only when a result is held back at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && $past(out_valid_o))
    else $error("input stalled without output backpressure");

endmodule

bind lidar_frame_deframer lfd_checker u_lfd_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_stall_o            (in_stall_o),
  .out_valid_o           (out_valid_o),
  .out_stall_i           (out_stall_i),
  .range_cm_o            (range_cm_o),
  .strength_o            (strength_o),
  .temperature_eighths_o (temperature_eighths_o),
  .checksum_ok_o         (checksum_ok_o)
);

/* dv/tb_lidar_frame_deframer.sv */
`timescale 1ns / 1ps

module tb_lidar_frame_deframer;
  import lfd_pkg::*;

  // Header hunt state of the frame predictor.
  typedef enum logic [1:0] {
    HUNT_FIRST  = 2'd0,
    HUNT_SECOND = 2'd1,
    COLLECT     = 2'd2
  } hunt_phase_e;

  // One decoded frame as seen on the output channel.
  typedef struct packed {
    logic [15:0]        distance;
    logic [15:0]        strength;
    logic signed [16:0] temperature;
    logic               sum_ok;
  } frame_result_t;

  localparam int unsigned DrainCycles = 8;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               cfg_we      = 1'b0;
  logic [15:0]        cfg_wdata   = '0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_byte     = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [15:0]        range_cm;
  logic [15:0]        strength;
  logic signed [16:0] temperature_eighths;
  logic               checksum_ok;

  // Predictor state, mirrors the deframer.
  hunt_phase_e hunt_phase   = HUNT_FIRST;
  logic [2:0]  payload_idx  = '0;
  logic [7:0]  frame_sum    = '0;
  logic [7:0]  payload_buf [PayloadLen];
  logic [15:0] bad_marker   = MarkerReset;

  frame_result_t expected_frames [$];
  int unsigned   mismatch_count = 0;
  int unsigned   bytes_sent     = 0;

  // Sender burst and receiver stall pattern state.
  int unsigned burst_left   = 0;
  int unsigned stall_mode   = 0;
  int unsigned stall_run    = 0;
  int unsigned hold_left    = 0;
  int unsigned hold_request = 0;

  lidar_frame_deframer u_top (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_wdata_i           (cfg_wdata),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .rx_byte_i             (rx_byte),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .range_cm_o            (range_cm),
    .strength_o            (strength),
    .temperature_eighths_o (temperature_eighths),
    .checksum_ok_o         (checksum_ok)
  );

  always #5 clk = ~clk;

  // Advance the frame predictor by one accepted byte.
  function automatic void predict_frame(input logic [7:0] b);
    frame_result_t res;
    case (hunt_phase)
      COLLECT: begin
        if (payload_idx < PayloadLen) begin
          payload_buf[payload_idx] = b;
          frame_sum = frame_sum + b;
          payload_idx = payload_idx + 3'd1;
        end else begin
          hunt_phase = HUNT_FIRST;
          payload_idx = '0;
          if (b == frame_sum) begin
            res.distance = {payload_buf[1], payload_buf[0]};
            res.strength = {payload_buf[3], payload_buf[2]};
            res.temperature = $signed({1'b0, payload_buf[5], payload_buf[4]}) - TempOffset;
            res.sum_ok = 1'b1;
          end else begin
            res.distance = bad_marker;
            res.strength = bad_marker;
            res.temperature = '0;
            res.sum_ok = 1'b0;
          end
          expected_frames.push_back(res);
        end
      end
      HUNT_SECOND: begin
        if (b == HdrByte) begin
          frame_sum = frame_sum + HdrByte;
          payload_idx = '0;
          hunt_phase = COLLECT;
        end else begin
          hunt_phase = HUNT_FIRST;
        end
      end
      default: begin
        if (b == HdrByte) begin
          frame_sum = HdrByte;
          hunt_phase = HUNT_SECOND;
        end else begin
          hunt_phase = HUNT_FIRST;
        end
        payload_idx = '0;
      end
    endcase
  endfunction

  function automatic void flag_mismatch(input string what, input int exp_v, input int act_v);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
  endfunction

  // Check each accepted result word.
  always @(posedge clk) begin : result_check
    frame_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        mismatch_count++;
        $display("%0t: result word with no frame pending, expected none, got dist %0d",
                 $time, range_cm);
      end else begin
        exp_r = expected_frames.pop_front();
        if (range_cm !== exp_r.distance) begin
          flag_mismatch("range_cm", exp_r.distance, range_cm);
        end
        if (strength !== exp_r.strength) begin
          flag_mismatch("strength", exp_r.strength, strength);
        end
        if (temperature_eighths !== exp_r.temperature) begin
          flag_mismatch("temperature_eighths", exp_r.temperature, temperature_eighths);
        end
        if (checksum_ok !== exp_r.sum_ok) begin
          flag_mismatch("checksum_ok", exp_r.sum_ok, checksum_ok);
        end
      end
    end
  end

  // Receiver stall pattern; a requested long hold-off takes priority.
  always @(posedge clk) begin : stall_drive
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_run = $urandom_range(5, 60);
      end
      stall_run--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Offer one byte, with a random gap, possibly none, before each burst.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    predict_frame(b);
  endtask

  // Payload byte with extra weight on the edge values and the header value.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return HdrByte;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Send a complete frame with random payload and a good or corrupt checksum.
  task automatic send_frame(input bit good_sum);
    logic [7:0] body [PayloadLen];
    logic [7:0] sum;
    sum = HdrByte + HdrByte;
    for (int i = 0; i < PayloadLen; i++) begin
      body[i] = pick_byte();
      sum = sum + body[i];
    end
    send_byte(HdrByte);
    send_byte(HdrByte);
    for (int i = 0; i < PayloadLen; i++) begin
      send_byte(body[i]);
    end
    send_byte(good_sum ? sum : sum + 8'($urandom_range(1, 255)));
  endtask

  // Let all pending results drain and the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_marker(input logic [15:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    bad_marker = value;
  endtask

  // Sliding header match, third header byte as payload, edge payloads, bad checksum.
  task automatic test_directed();
    logic [7:0] seq [$];
    seq = {HdrByte, 8'h00,
           HdrByte, HdrByte, HdrByte, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h06,
           HdrByte, HdrByte, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hB2,
           HdrByte, HdrByte, 8'h12, HdrByte, 8'h34, 8'h56, 8'h78, 8'h9A, 8'h00};
    // The FF frame sums to 0x59*3 + 0xFF*5 = 0x06 modulo 256.
    foreach (seq[i]) begin
      send_byte(seq[i]);
    end
  endtask

  // Bad and good frames under the extreme marker values.
  task automatic test_marker_extremes();
    write_marker(16'h0000);
    send_frame(1'b0);
    send_frame(1'b1);
    write_marker(16'hFFFF);
    send_frame(1'b0);
    send_frame(1'b1);
  endtask

  // Long receiver hold-off while frames keep arriving, to fill the frame queue.
  task automatic test_backpressure();
    wait_idle();
    hold_request = 400;
    for (int i = 0; i < 20; i++) begin
      send_frame($urandom_range(0, 3) != 0);
    end
  endtask

  // Mostly well-formed frames, with noise and truncated or broken headers.
  task automatic test_random_traffic(input int unsigned n_bytes);
    int unsigned start;
    int unsigned k;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      case ($urandom_range(0, 9))
        8: begin
          k = $urandom_range(1, 5);
          repeat (k) send_byte(pick_byte());
        end
        9: begin
          send_byte(HdrByte);
          if ($urandom_range(0, 1) == 0) begin
            send_byte(8'($urandom_range(0, HdrByte - 1)));
          end else begin
            send_byte(HdrByte);
            k = $urandom_range(0, 5);
            repeat (k) send_byte(pick_byte());
          end
        end
        default: send_frame($urandom_range(0, 3) != 0);
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_marker_extremes();
    test_backpressure();
    for (int p = 0; p < 4; p++) begin
      write_marker(16'($urandom_range(0, 65535)));
      test_random_traffic(320);
    end
    wait_idle();

    if (mismatch_count == 0 && expected_frames.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
